### hdl/lle_pkg.sv
// lle_pkg: shared types and codes for the linked-list engine
// used by linked_list_engine; no dependencies
package lle_pkg;

    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_INS_AFTER = 3'd1;
    localparam logic [2:0] ACT_INS_BACK  = 3'd2;
    localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [2:0] ACT_DEL_KEY   = 3'd4;
    localparam logic [2:0] ACT_DEL_BACK  = 3'd5;
    localparam logic [2:0] ACT_REVERSE   = 3'd6;
    localparam logic [2:0] ACT_READ_OUT  = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
        logic signed [31:0] key;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         element_count;
        logic signed [31:0] element_value;
        logic               last_item;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK_RD,
        S_WALK_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_LINK_WR,
        S_GIVE,
        S_REPLY
    } t_state;

endpackage

### hdl/linked_list_engine.sv
// linked_list_engine: ordered list of signed values in a bounded node store
// depends on lle_pkg and lle_ram
//
// Input channel i_in_valid / o_in_stall carries one command (action, value,
// key). Output channel o_out_valid / i_out_stall returns results: one per
// command, or one per element for a read-out, the last flagged by last_item.
// One command is taken at a time; o_in_stall stays high until its last
// result sits in the output register.
// Commands that search or traverse the list walk it node by node, reading
// each node from the value and link memories in a read state and then a
// check state; insert front and insert back take a free node without a walk.
// An empty list or a full store replies without a walk, a missing key after
// the whole walk.
// Synchronous reset empties the list and chains all nodes as free; the link
// store needs no clearing pass. When the receiver stalls, the output
// register holds its result and the sequencer waits before loading the next.
module linked_list_engine #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lle_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lle_pkg::t_out o_out_data
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

    lle_pkg::t_state r_state, n_state;

    logic [2:0]                    r_act, n_act;
    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic signed [VALUE_WIDTH-1:0] r_key, n_key;
    logic [1:0]                    r_st, n_st;
    logic [IDX_W-1:0]              r_head, n_head;
    logic [IDX_W-1:0]              r_tail, n_tail;
    logic [IDX_W-1:0]              r_free, n_free;
    logic [IDX_W-1:0]              r_cnt, n_cnt;
    logic [IDX_W-1:0]              r_cur, n_cur;
    logic [IDX_W-1:0]              r_prev, n_prev;
    logic [IDX_W-1:0]              r_found, n_found;
    logic [IDX_W-1:0]              r_nxt, n_nxt;
    logic [AW-1:0]                 r_pw_addr, n_pw_addr;
    logic [IDX_W-1:0]              r_pw_data, n_pw_data;
    logic [AW-1:0]                 r_raddr, n_raddr;
    logic [CAPACITY-1:0]           r_lvld, n_lvld;
    logic                          r_ovld, n_ovld;
    lle_pkg::t_out                 r_out, n_out;

    // memory ports
    logic                    w_re;
    logic [AW-1:0]           w_ra;
    logic                    w_vwe;
    logic [AW-1:0]           w_vwa;
    logic [VALUE_WIDTH-1:0]  w_vwd;
    logic [VALUE_WIDTH-1:0]  w_vq_raw;
    logic signed [VALUE_WIDTH-1:0] w_vq;
    logic                    w_lwe;
    logic [AW-1:0]           w_lwa;
    logic [IDX_W-1:0]        w_lwd;
    logic [IDX_W-1:0]        w_lq;
    logic [IDX_W-1:0]        w_lnk;

    logic w_empty, w_full, w_match, w_nil, w_can_load;
    logic [IDX_W-1:0] w_new_head;

    lle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_values (
        .i_clk  (i_clk),
        .i_we   (w_vwe),
        .i_waddr(w_vwa),
        .i_wdata(w_vwd),
        .i_re   (w_re),
        .i_raddr(w_ra),
        .o_rdata(w_vq_raw)
    );

    lle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_links (
        .i_clk  (i_clk),
        .i_we   (w_lwe),
        .i_waddr(w_lwa),
        .i_wdata(w_lwd),
        .i_re   (w_re),
        .i_raddr(w_ra),
        .o_rdata(w_lq)
    );

    assign w_vq = w_vq_raw;
    // a link never written still holds its reset chaining to the next entry
    assign w_lnk = r_lvld[r_raddr] ? w_lq : (IDX_W'(r_raddr) + IDX_W'(1));

    assign w_empty    = (r_head == NIL);
    assign w_full     = (r_free == NIL);
    assign w_match    = (w_vq == r_key);
    assign w_nil      = (w_lnk == NIL);
    assign w_can_load = !r_ovld || !i_out_stall;
    assign w_new_head = (r_cur == r_head) ? w_lnk : r_head;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lle_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lle_pkg::S_DISPATCH;
            end
            lle_pkg::S_DISPATCH: begin
                case (r_act)
                    lle_pkg::ACT_INS_FRONT, lle_pkg::ACT_INS_BACK: begin
                        n_state = w_full ? lle_pkg::S_REPLY : lle_pkg::S_FREE_RD;
                    end
                    lle_pkg::ACT_INS_AFTER: begin
                        n_state = (w_full || w_empty) ? lle_pkg::S_REPLY : lle_pkg::S_WALK_RD;
                    end
                    lle_pkg::ACT_DEL_BACK: begin
                        if (w_empty) n_state = lle_pkg::S_REPLY;
                        else if (r_head == r_tail) n_state = lle_pkg::S_GIVE;
                        else n_state = lle_pkg::S_WALK_RD;
                    end
                    default: begin
                        n_state = w_empty ? lle_pkg::S_REPLY : lle_pkg::S_WALK_RD;
                    end
                endcase
            end
            lle_pkg::S_WALK_RD: n_state = lle_pkg::S_WALK_CHK;
            lle_pkg::S_WALK_CHK: begin
                case (r_act)
                    lle_pkg::ACT_INS_AFTER: begin
                        if (w_match) n_state = lle_pkg::S_FREE_RD;
                        else if (w_nil) n_state = lle_pkg::S_REPLY;
                        else n_state = lle_pkg::S_WALK_RD;
                    end
                    lle_pkg::ACT_DEL_FRONT: n_state = lle_pkg::S_GIVE;
                    lle_pkg::ACT_DEL_KEY: begin
                        if (w_match) n_state = lle_pkg::S_GIVE;
                        else if (w_nil) n_state = lle_pkg::S_REPLY;
                        else n_state = lle_pkg::S_WALK_RD;
                    end
                    lle_pkg::ACT_DEL_BACK: begin
                        n_state = (w_lnk == r_tail) ? lle_pkg::S_GIVE : lle_pkg::S_WALK_RD;
                    end
                    lle_pkg::ACT_REVERSE: begin
                        n_state = w_nil ? lle_pkg::S_REPLY : lle_pkg::S_WALK_RD;
                    end
                    lle_pkg::ACT_READ_OUT: begin
                        if (w_can_load) n_state = w_nil ? lle_pkg::S_IDLE : lle_pkg::S_WALK_RD;
                    end
                    default: n_state = lle_pkg::S_REPLY;
                endcase
            end
            lle_pkg::S_FREE_RD: n_state = lle_pkg::S_FREE_CHK;
            lle_pkg::S_FREE_CHK: begin
                if (r_act == lle_pkg::ACT_INS_AFTER ||
                    (r_act == lle_pkg::ACT_INS_BACK && !w_empty)) begin
                    n_state = lle_pkg::S_LINK_WR;
                end else begin
                    n_state = lle_pkg::S_REPLY;
                end
            end
            lle_pkg::S_LINK_WR: n_state = lle_pkg::S_REPLY;
            lle_pkg::S_GIVE:    n_state = lle_pkg::S_REPLY;
            lle_pkg::S_REPLY: begin
                if (w_can_load) n_state = lle_pkg::S_IDLE;
            end
            default: n_state = lle_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_act     = r_act;
        n_val     = r_val;
        n_key     = r_key;
        n_st      = r_st;
        n_head    = r_head;
        n_tail    = r_tail;
        n_free    = r_free;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_found   = r_found;
        n_nxt     = r_nxt;
        n_pw_addr = r_pw_addr;
        n_pw_data = r_pw_data;
        n_raddr   = r_raddr;
        n_lvld    = r_lvld;
        n_ovld    = r_ovld && i_out_stall;
        n_out     = r_out;
        w_re      = 1'b0;
        w_ra      = r_cur[AW-1:0];
        w_vwe     = 1'b0;
        w_vwa     = r_free[AW-1:0];
        w_vwd     = r_val;
        w_lwe     = 1'b0;
        w_lwa     = r_cur[AW-1:0];
        w_lwd     = NIL;

        case (r_state)
            lle_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_act = i_in_data.action;
                    n_val = VALUE_WIDTH'(i_in_data.value);
                    n_key = VALUE_WIDTH'(i_in_data.key);
                    n_st  = lle_pkg::ST_OK;
                end
            end
            lle_pkg::S_DISPATCH: begin
                n_cur  = r_head;
                n_prev = NIL;
                case (r_act)
                    lle_pkg::ACT_INS_FRONT, lle_pkg::ACT_INS_BACK: begin
                        if (w_full) n_st = lle_pkg::ST_FULL;
                    end
                    lle_pkg::ACT_INS_AFTER: begin
                        if (w_full) n_st = lle_pkg::ST_FULL;
                        else if (w_empty) n_st = lle_pkg::ST_EMPTY;
                    end
                    lle_pkg::ACT_DEL_BACK: begin
                        if (w_empty) begin
                            n_st = lle_pkg::ST_EMPTY;
                        end else if (r_head == r_tail) begin
                            n_head  = NIL;
                            n_tail  = NIL;
                            n_found = r_tail;
                        end
                    end
                    lle_pkg::ACT_REVERSE: begin
                        if (w_empty) n_st = lle_pkg::ST_EMPTY;
                        else n_tail = r_head;
                    end
                    default: begin
                        if (w_empty) n_st = lle_pkg::ST_EMPTY;
                    end
                endcase
            end
            lle_pkg::S_WALK_RD: begin
                w_re    = 1'b1;
                w_ra    = r_cur[AW-1:0];
                n_raddr = r_cur[AW-1:0];
            end
            lle_pkg::S_WALK_CHK: begin
                case (r_act)
                    lle_pkg::ACT_INS_AFTER: begin
                        if (w_match) begin
                            n_found = r_cur;
                            n_nxt   = w_lnk;
                        end else if (w_nil) begin
                            n_st = lle_pkg::ST_NOT_FOUND;
                        end else begin
                            n_prev = r_cur;
                            n_cur  = w_lnk;
                        end
                    end
                    lle_pkg::ACT_DEL_FRONT: begin
                        n_head  = w_lnk;
                        n_found = r_cur;
                        if (w_nil) n_tail = NIL;
                    end
                    lle_pkg::ACT_DEL_KEY: begin
                        if (w_match) begin
                            n_found = r_cur;
                            if (r_cur == r_head) begin
                                n_head = w_lnk;
                            end else begin
                                w_lwe = 1'b1;
                                w_lwa = r_prev[AW-1:0];
                                w_lwd = w_lnk;
                            end
                            if (r_cur == r_tail) begin
                                n_tail = (w_new_head == NIL) ? NIL : r_prev;
                            end
                        end else if (w_nil) begin
                            n_st = lle_pkg::ST_NOT_FOUND;
                        end else begin
                            n_prev = r_cur;
                            n_cur  = w_lnk;
                        end
                    end
                    lle_pkg::ACT_DEL_BACK: begin
                        if (w_lnk == r_tail) begin
                            w_lwe   = 1'b1;
                            w_lwa   = r_cur[AW-1:0];
                            w_lwd   = NIL;
                            n_found = r_tail;
                            n_tail  = r_cur;
                        end else begin
                            n_cur = w_lnk;
                        end
                    end
                    lle_pkg::ACT_REVERSE: begin
                        w_lwe  = 1'b1;
                        w_lwa  = r_cur[AW-1:0];
                        w_lwd  = r_prev;
                        n_prev = r_cur;
                        n_cur  = w_lnk;
                        if (w_nil) n_head = r_cur;
                    end
                    lle_pkg::ACT_READ_OUT: begin
                        if (w_can_load) begin
                            n_ovld                  = 1'b1;
                            n_out.status            = lle_pkg::ST_OK;
                            n_out.element_count     = 6'(r_cnt);
                            n_out.element_value     = 32'(w_vq);
                            n_out.last_item         = w_nil;
                            n_cur                   = w_lnk;
                        end
                    end
                    default: ;
                endcase
            end
            lle_pkg::S_FREE_RD: begin
                w_re    = 1'b1;
                w_ra    = r_free[AW-1:0];
                n_raddr = r_free[AW-1:0];
            end
            lle_pkg::S_FREE_CHK: begin
                // pop the free head into the value and link stores
                w_vwe  = 1'b1;
                w_vwa  = r_free[AW-1:0];
                w_lwe  = 1'b1;
                w_lwa  = r_free[AW-1:0];
                n_free = w_lnk;
                n_cnt  = r_cnt + IDX_W'(1);
                if (r_act == lle_pkg::ACT_INS_AFTER) begin
                    w_lwd     = r_nxt;
                    n_pw_addr = r_found[AW-1:0];
                    n_pw_data = r_free;
                    if (r_found == r_tail) n_tail = r_free;
                end else if (w_empty) begin
                    w_lwd  = NIL;
                    n_head = r_free;
                    n_tail = r_free;
                end else if (r_act == lle_pkg::ACT_INS_FRONT) begin
                    w_lwd  = r_head;
                    n_head = r_free;
                end else begin
                    w_lwd     = NIL;
                    n_pw_addr = r_tail[AW-1:0];
                    n_pw_data = r_free;
                    n_tail    = r_free;
                end
            end
            lle_pkg::S_LINK_WR: begin
                w_lwe = 1'b1;
                w_lwa = r_pw_addr;
                w_lwd = r_pw_data;
            end
            lle_pkg::S_GIVE: begin
                // freed node goes to the front of the free list
                w_lwe  = 1'b1;
                w_lwa  = r_found[AW-1:0];
                w_lwd  = r_free;
                n_free = r_found;
                n_cnt  = r_cnt - IDX_W'(1);
            end
            lle_pkg::S_REPLY: begin
                if (w_can_load) begin
                    n_ovld              = 1'b1;
                    n_out.status        = r_st;
                    n_out.element_count = 6'(r_cnt);
                    n_out.element_value = '0;
                    n_out.last_item     = 1'b1;
                end
            end
            default: ;
        endcase

        if (w_lwe) n_lvld[w_lwa] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lle_pkg::S_IDLE;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_free  <= '0;
            r_cnt   <= '0;
            r_lvld  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_cnt   <= n_cnt;
            r_lvld  <= n_lvld;
            r_ovld  <= n_ovld;
        end
        r_act     <= n_act;
        r_val     <= n_val;
        r_key     <= n_key;
        r_st      <= n_st;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_found   <= n_found;
        r_nxt     <= n_nxt;
        r_pw_addr <= n_pw_addr;
        r_pw_data <= n_pw_data;
        r_raddr   <= n_raddr;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != lle_pkg::S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= IDX_W'(CAPACITY))
        else $error("element count above capacity");

    a_head_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lle_pkg::S_IDLE) |-> ((r_head == NIL) == (r_cnt == '0)))
        else $error("list head and element count disagree");

    a_free_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lle_pkg::S_IDLE) |-> ((r_free == NIL) == (r_cnt == IDX_W'(CAPACITY))))
        else $error("free list and element count disagree");

    a_tail_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lle_pkg::S_IDLE) |-> ((r_tail == NIL) == (r_head == NIL)))
        else $error("list tail and head disagree on empty");

endmodule

### hdl/lle_ram.sv
// lle_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module lle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### dv/testbench.sv
// testbench: random and directed commands against linked_list_engine, results
// checked in order against a behavioural list model held in a scoreboard class
// depends on lle_pkg and the engine rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;
    localparam logic [5:0] NIL = 6'(CAP);

    class list_scoreboard;
        logic signed [31:0] vals [CAP];
        logic [5:0] links [CAP];
        logic [5:0] head, tail, free_head;
        int unsigned used;
        lle_pkg::t_out pending[$];
        int unsigned errors;

        function void clear();
            for (int i = 0; i < CAP; i++) begin
                vals[i] = '0;
                links[i] = 6'(i + 1);
            end
            head = NIL;
            tail = NIL;
            free_head = 0;
            used = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void push(logic [1:0] st, logic signed [31:0] v, logic last);
            lle_pkg::t_out r;
            r.status = st;
            r.element_count = 6'(used);
            r.element_value = v;
            r.last_item = last;
            pending.push_back(r);
        endfunction

        function bit in_store(logic [5:0] i);
            return i < CAP;
        endfunction

        function logic [5:0] take_node();
            logic [5:0] n;
            n = free_head;
            free_head = links[n];
            used++;
            return n;
        endfunction

        function void give_node(logic [5:0] n);
            links[n] = free_head;
            free_head = n;
            if (used > 0) used--;
        endfunction

        // work out the results of one accepted command
        function void note_command(lle_pkg::t_in c);
            logic [5:0] n, p, cur, nx;
            logic [1:0] st;
            bit empty;
            int k;
            st = lle_pkg::ST_OK;
            empty = !in_store(head);
            case (c.action)
                lle_pkg::ACT_INS_FRONT, lle_pkg::ACT_INS_BACK: begin
                    if (!in_store(free_head)) st = lle_pkg::ST_FULL;
                    else begin
                        n = take_node();
                        vals[n] = c.value;
                        if (empty) begin
                            links[n] = NIL; head = n; tail = n;
                        end else if (c.action == lle_pkg::ACT_INS_FRONT) begin
                            links[n] = head; head = n;
                        end else begin
                            links[n] = NIL; links[tail] = n; tail = n;
                        end
                    end
                end
                lle_pkg::ACT_INS_AFTER: begin
                    if (!in_store(free_head)) st = lle_pkg::ST_FULL;
                    else if (empty) st = lle_pkg::ST_EMPTY;
                    else begin
                        cur = head;
                        while (in_store(cur) && vals[cur] != c.key) cur = links[cur];
                        if (!in_store(cur)) st = lle_pkg::ST_NOT_FOUND;
                        else begin
                            n = take_node();
                            vals[n] = c.value;
                            links[n] = links[cur];
                            links[cur] = n;
                            if (cur == tail) tail = n;
                        end
                    end
                end
                lle_pkg::ACT_DEL_FRONT: begin
                    if (empty) st = lle_pkg::ST_EMPTY;
                    else begin
                        cur = head;
                        head = links[cur];
                        if (!in_store(head)) tail = NIL;
                        give_node(cur);
                    end
                end
                lle_pkg::ACT_DEL_KEY: begin
                    if (empty) st = lle_pkg::ST_EMPTY;
                    else begin
                        p = NIL;
                        cur = head;
                        while (in_store(cur) && vals[cur] != c.key) begin
                            p = cur; cur = links[cur];
                        end
                        if (!in_store(cur)) st = lle_pkg::ST_NOT_FOUND;
                        else begin
                            if (cur == head) head = links[cur];
                            else links[p] = links[cur];
                            if (cur == tail) tail = in_store(head) ? p : NIL;
                            give_node(cur);
                        end
                    end
                end
                lle_pkg::ACT_DEL_BACK: begin
                    if (empty) st = lle_pkg::ST_EMPTY;
                    else begin
                        cur = tail;
                        if (head == tail) begin
                            head = NIL; tail = NIL;
                        end else begin
                            p = head;
                            while (links[p] != cur) p = links[p];
                            links[p] = NIL;
                            tail = p;
                        end
                        give_node(cur);
                    end
                end
                lle_pkg::ACT_REVERSE: begin
                    if (empty) st = lle_pkg::ST_EMPTY;
                    else begin
                        p = NIL;
                        cur = head;
                        tail = head;
                        while (in_store(cur)) begin
                            nx = links[cur]; links[cur] = p; p = cur; cur = nx;
                        end
                        head = p;
                    end
                end
                default: begin
                    if (empty) push(lle_pkg::ST_EMPTY, '0, 1'b1);
                    else begin
                        cur = head;
                        k = 0;
                        while (in_store(cur) && k < CAP) begin
                            nx = links[cur];
                            push(lle_pkg::ST_OK, vals[cur], !in_store(nx) || k + 1 >= CAP);
                            k++;
                            cur = nx;
                        end
                    end
                    return;
                end
            endcase
            push(st, '0, 1'b1);
        endfunction

        function void check_result(lle_pkg::t_out got);
            lle_pkg::t_out exp_r;
            if (pending.size() == 0) begin
                $error("result with nothing outstanding: %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status) begin
                $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
            end
            if (got.element_count !== exp_r.element_count) begin
                $error("element_count exp %0d got %0d", exp_r.element_count,
                       got.element_count);
                errors++;
            end
            if (got.element_value !== exp_r.element_value) begin
                $error("element_value exp %0d got %0d", exp_r.element_value,
                       got.element_value);
                errors++;
            end
            if (got.last_item !== exp_r.last_item) begin
                $error("last_item exp %0d got %0d", exp_r.last_item, got.last_item);
                errors++;
            end
        endfunction

        // pick a value currently in the list, or a random one when empty
        function logic signed [31:0] some_member();
            logic [5:0] cur;
            int steps;
            cur = head;
            if (!in_store(cur)) return $urandom;
            steps = $urandom_range(0, used - 1);
            while (steps > 0 && in_store(links[cur])) begin
                cur = links[cur]; steps--;
            end
            return vals[cur];
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    lle_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    lle_pkg::t_out o_out_data;

    list_scoreboard sb = new();
    bit calm = 1'b0;

    linked_list_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stalls, none during the calm stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        i_out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    // valid stays high into the next transaction unless an idle gap is taken
    task automatic send(logic [2:0] act, logic signed [31:0] v, logic signed [31:0] k);
        lle_pkg::t_in c;
        c.action = act;
        c.value = v;
        c.key = k;
        while (!calm && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_command(c);
    endtask

    task automatic random_command();
        int r;
        logic signed [31:0] v, k;
        r = $urandom_range(0, 99);
        v = $urandom;
        k = ($urandom_range(0, 3) != 0) ? sb.some_member() : $urandom;
        // bias toward growth while short so the store fills up now and then
        if (r < (sb.used < 20 ? 45 : 25)) send(3'($urandom_range(0, 2)), v, k);
        else send(3'($urandom_range(3, 7)), v, k);
    endtask

    initial begin
        sb.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty list cases
        send(lle_pkg::ACT_READ_OUT, 0, 0);
        send(lle_pkg::ACT_DEL_FRONT, 0, 0);
        send(lle_pkg::ACT_DEL_KEY, 0, 5);
        send(lle_pkg::ACT_DEL_BACK, 0, 0);
        send(lle_pkg::ACT_REVERSE, 0, 0);
        send(lle_pkg::ACT_INS_AFTER, 1, 1);
        // one element, delete back empties it
        send(lle_pkg::ACT_INS_BACK, 32'sh7fffffff, 0);
        send(lle_pkg::ACT_DEL_BACK, 0, 0);
        send(lle_pkg::ACT_INS_FRONT, 32'sh80000000, 0);
        send(lle_pkg::ACT_INS_BACK, -1, 0);
        send(lle_pkg::ACT_INS_AFTER, 0, -1);          // key at tail
        send(lle_pkg::ACT_INS_AFTER, 9, 32'sh80000000);
        send(lle_pkg::ACT_INS_AFTER, 9, 1234);        // key absent
        send(lle_pkg::ACT_DEL_KEY, 0, 1234);
        send(lle_pkg::ACT_REVERSE, 0, 0);
        send(lle_pkg::ACT_READ_OUT, 0, 0);
        send(lle_pkg::ACT_DEL_KEY, 0, 0);             // key 0 was the tail and is the head after reverse
        send(lle_pkg::ACT_DEL_KEY, 0, 32'sh80000000);
        // fill to capacity and beyond
        while (sb.used < CAP) send(lle_pkg::ACT_INS_BACK, $urandom, 0);
        send(lle_pkg::ACT_INS_FRONT, 1, 0);
        send(lle_pkg::ACT_INS_AFTER, 1, sb.some_member());
        send(lle_pkg::ACT_READ_OUT, 0, 0);
        send(lle_pkg::ACT_REVERSE, 0, 0);
        send(lle_pkg::ACT_READ_OUT, 0, 0);
        for (int i = 0; i < 317; i++) begin
            calm = (i >= 150 && i < 200);
            random_command();
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end
endmodule

### linked_list_engine.f
hdl/lle_pkg.sv
hdl/lle_ram.sv
hdl/linked_list_engine.sv
dv/testbench.sv
